// ===== hw/rtl/cpu_alu_with_flags_top_assert.svh =====
// assertion macros for the alu with flags block
`ifndef CPU_ALU_WITH_FLAGS_TOP_ASSERT_SVH
`define CPU_ALU_WITH_FLAGS_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define CAL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cal_pkg.sv =====
// shared types, opcodes and constants for the alu with flags block
`timescale 1ns / 1ps

package cal_pkg;

    localparam int OP_W      = 6;
    localparam int WORD_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int BIT_IDX_W = 3;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    // queue between front and back, depth is a power of two so pointers wrap
    localparam int QDEPTH = 2;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [BYTE_W-1:0] DAA_LIMIT = 8'h99;
    localparam logic [BYTE_W-1:0] DAA_HI    = 8'h60;
    localparam logic [BYTE_W-1:0] DAA_LO    = 8'h06;
    localparam logic [3:0]        NIB_NINE  = 4'h9;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 6'd0,
        OP_ADC    = 6'd1,
        OP_SUB    = 6'd2,
        OP_SBC    = 6'd3,
        OP_AND    = 6'd4,
        OP_OR     = 6'd5,
        OP_XOR    = 6'd6,
        OP_CP     = 6'd7,
        OP_INC8   = 6'd8,
        OP_DEC8   = 6'd9,
        OP_INC16  = 6'd10,
        OP_DEC16  = 6'd11,
        OP_ADD16  = 6'd12,
        OP_ADDSP  = 6'd13,
        OP_RLCA   = 6'd14,
        OP_RRCA   = 6'd15,
        OP_RLA    = 6'd16,
        OP_RRA    = 6'd17,
        OP_DAA    = 6'd18,
        OP_CPL    = 6'd19,
        OP_SCF    = 6'd20,
        OP_CCF    = 6'd21,
        OP_RLC    = 6'd22,
        OP_RRC    = 6'd23,
        OP_RL     = 6'd24,
        OP_RR     = 6'd25,
        OP_SLA    = 6'd26,
        OP_SRA    = 6'd27,
        OP_SWAP   = 6'd28,
        OP_SRL    = 6'd29,
        OP_BIT    = 6'd30,
        OP_RES    = 6'd31,
        OP_SET    = 6'd32
    } op_t;

    // execution class chosen by the front
    typedef enum logic [2:0] {
        CLS_ARITH8,
        CLS_LOGIC8,
        CLS_INCDEC,
        CLS_WIDE16,
        CLS_ACC,
        CLS_CB,
        CLS_NONE
    } cls_t;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    typedef struct packed {
        cls_t                  cls;
        op_t                   op;
        logic [WORD_W-1:0]     a16;
        logic [WORD_W-1:0]     b16;
        logic [BIT_IDX_W-1:0]  bit_idx;
    } item_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_status_t;

endpackage

// ===== hw/rtl/cpu_alu_with_flags_top.sv =====
// top level of the 8-bit cpu alu with z/n/h/c flag register
`timescale 1ns / 1ps

// alu for an 8-bit handheld-console cpu: each input word carries an opcode,
// two 16-bit operands and a bit index; each produces exactly one output word
// with the result and the z/n/h/c flags after the operation. the flag register
// lives inside and resets to zero; adc, sbc, rotates through carry, daa, ccf
// and friends read it, so ops are executed strictly in arrival order.
// while m_axis_tready is not held low, throughput is one word per clock: the
// front decodes and writes a two-entry queue, the back pops one entry per cycle,
// computes combinationally and loads the output register, which also commits
// the flags. an accepted word goes into the queue, then into the output register.
// the input stalls only when the queue is full, i.e. when the output side has
// been holding m_axis_tready low. opcodes 33 to 63 return zero and keep the flags.

module cpu_alu_with_flags_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[5:0], operand_a[21:6], operand_b[37:22], bit_index[40:38], zero fill
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result[15:0], flag_zero[16], flag_subtract[17], flag_half[18],
    // flag_carry[19], zero fill
    output logic [23:0] m_axis_tdata
);
    import cal_pkg::*;

    logic      q_push;
    logic      q_pop;
    item_t     q_wr_item;
    item_t     q_rd_item;
    q_status_t q_status;

    cal_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_item        (q_wr_item)
    );

    // decoded words waiting for the execute side
    cal_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_wr_item),
        .pop       (q_pop),
        .pop_item  (q_rd_item),
        .status    (q_status)
    );

    // execute, flag register and output register
    cal_exec u_exec (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .q_item        (q_rd_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

`include "cpu_alu_with_flags_top_assert.svh"

    // input may only stall when the queue is actually full
    `CAL_ASSERT_NOW(a_stall_only_full, !s_axis_tready, q_status.full, "input stalled with room in queue")

    // never pop an empty queue
    `CAL_ASSERT_NOW(a_pop_nonempty, q_pop, !q_status.empty, "pop from empty queue")

    // an accepted word is held in the queue on the next edge
    `CAL_ASSERT_NEXT(a_accept_queued, s_axis_tvalid && s_axis_tready, !q_status.empty, "accepted word lost")

endmodule

// ===== hw/rtl/cal_queue.sv =====
// short in-order queue of decoded words between front and back
`timescale 1ns / 1ps

module cal_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cal_pkg::item_t     push_item,
    input  logic               pop,
    output cal_pkg::item_t     pop_item,
    output cal_pkg::q_status_t status
);
    import cal_pkg::*;

    item_t             mem_reg [QDEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QIDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item     = mem_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign status.empty = (cnt_reg == '0);
    assign status.count = cnt_reg;

endmodule

// ===== hw/rtl/cal_front.sv =====
// input side: takes words, unpacks the fields and sorts each op into a class
`timescale 1ns / 1ps

module cal_front (
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [cal_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  cal_pkg::q_status_t                q_status,
    output logic                              q_push,
    output cal_pkg::item_t                    q_item
);
    import cal_pkg::*;

    op_t op;

    assign op = op_t'(s_axis_tdata[OP_W-1:0]);

    always_comb
    begin
        q_item.op      = op;
        q_item.a16     = s_axis_tdata[OP_W +: WORD_W];
        q_item.b16     = s_axis_tdata[OP_W + WORD_W +: WORD_W];
        q_item.bit_idx = s_axis_tdata[OP_W + 2*WORD_W +: BIT_IDX_W];
        case (op)
            OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_CP:
                q_item.cls = CLS_ARITH8;
            OP_AND, OP_OR, OP_XOR:
                q_item.cls = CLS_LOGIC8;
            OP_INC8, OP_DEC8:
                q_item.cls = CLS_INCDEC;
            OP_INC16, OP_DEC16, OP_ADD16, OP_ADDSP:
                q_item.cls = CLS_WIDE16;
            OP_RLCA, OP_RRCA, OP_RLA, OP_RRA, OP_DAA, OP_CPL, OP_SCF, OP_CCF:
                q_item.cls = CLS_ACC;
            OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL,
            OP_BIT, OP_RES, OP_SET:
                q_item.cls = CLS_CB;
            default:
                q_item.cls = CLS_NONE;
        endcase
    end

    assign s_axis_tready = !q_status.full;
    assign q_push        = s_axis_tvalid && !q_status.full;

endmodule

// ===== hw/rtl/cal_exec.sv =====
// back side: executes one op per cycle unless the output stalls, owns the flag and output registers
`timescale 1ns / 1ps

module cal_exec (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cal_pkg::q_status_t                 q_status,
    input  cal_pkg::item_t                     q_item,
    output logic                               q_pop,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [cal_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import cal_pkg::*;

    flags_t             flags_reg, flags_next;
    logic               m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]  res_reg;
    logic [WORD_W-1:0]  res_next;
    flags_t             fout_reg;

    logic [BYTE_W-1:0]  a, b;
    logic               cin;

    assign a   = q_item.a16[BYTE_W-1:0];
    assign b   = q_item.b16[BYTE_W-1:0];
    assign cin = flags_reg.c;

    always_comb
    begin
        logic              cx;
        logic [BYTE_W:0]   s9;
        logic [4:0]        s5;
        logic [BYTE_W-1:0] r8;
        logic [WORD_W:0]   s17;
        logic [12:0]       s13;
        logic [WORD_W-1:0] sext;
        logic              dc;

        cx   = 1'b0;
        s9   = '0;
        s5   = '0;
        r8   = '0;
        s17  = '0;
        s13  = '0;
        sext = '0;
        dc   = cin;
        res_next   = '0;
        flags_next = flags_reg;

        case (q_item.cls)
            CLS_ARITH8:
            begin
                cx = ((q_item.op == OP_ADC) || (q_item.op == OP_SBC)) ? cin : 1'b0;
                if ((q_item.op == OP_ADD) || (q_item.op == OP_ADC))
                begin
                    s9 = {1'b0, a} + {1'b0, b} + {8'd0, cx};
                    s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cx};
                    flags_next.n = 1'b0;
                end
                else
                begin
                    // borrow out of bit 8 and bit 4
                    s9 = {1'b0, a} - {1'b0, b} - {8'd0, cx};
                    s5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cx};
                    flags_next.n = 1'b1;
                end
                res_next     = {8'd0, s9[BYTE_W-1:0]};
                flags_next.z = (s9[BYTE_W-1:0] == '0);
                flags_next.h = s5[4];
                flags_next.c = s9[BYTE_W];
            end
            CLS_LOGIC8:
            begin
                case (q_item.op)
                    OP_AND:  r8 = a & b;
                    OP_OR:   r8 = a | b;
                    default: r8 = a ^ b;
                endcase
                res_next     = {8'd0, r8};
                flags_next.z = (r8 == '0);
                flags_next.n = 1'b0;
                flags_next.h = (q_item.op == OP_AND);
                flags_next.c = 1'b0;
            end
            CLS_INCDEC:
            begin
                if (q_item.op == OP_INC8)
                begin
                    r8           = a + 1'b1;
                    flags_next.n = 1'b0;
                    flags_next.h = (r8[3:0] == 4'd0);
                end
                else
                begin
                    r8           = a - 1'b1;
                    flags_next.n = 1'b1;
                    flags_next.h = (a[3:0] == 4'd0);
                end
                res_next     = {8'd0, r8};
                flags_next.z = (r8 == '0);
            end
            CLS_WIDE16:
            begin
                case (q_item.op)
                    OP_INC16: res_next = q_item.a16 + 1'b1;
                    OP_DEC16: res_next = q_item.a16 - 1'b1;
                    OP_ADD16:
                    begin
                        s17 = {1'b0, q_item.a16} + {1'b0, q_item.b16};
                        s13 = {1'b0, q_item.a16[11:0]} + {1'b0, q_item.b16[11:0]};
                        res_next     = s17[WORD_W-1:0];
                        flags_next.n = 1'b0;
                        flags_next.h = s13[12];
                        flags_next.c = s17[WORD_W];
                    end
                    default:
                    begin
                        // sp plus signed byte, flags from the low byte add
                        sext = {{8{b[7]}}, b};
                        s9   = {1'b0, q_item.a16[BYTE_W-1:0]} + {1'b0, b};
                        s5   = {1'b0, q_item.a16[3:0]} + {1'b0, b[3:0]};
                        res_next     = q_item.a16 + sext;
                        flags_next.z = 1'b0;
                        flags_next.n = 1'b0;
                        flags_next.h = s5[4];
                        flags_next.c = s9[BYTE_W];
                    end
                endcase
            end
            CLS_ACC:
            begin
                case (q_item.op)
                    OP_RLCA:
                    begin
                        r8 = {a[6:0], a[7]};
                        flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
                    end
                    OP_RRCA:
                    begin
                        r8 = {a[0], a[7:1]};
                        flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
                    end
                    OP_RLA:
                    begin
                        r8 = {a[6:0], cin};
                        flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
                    end
                    OP_RRA:
                    begin
                        r8 = {cin, a[7:1]};
                        flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
                    end
                    OP_DAA:
                    begin
                        r8 = a;
                        if (!flags_reg.n)
                        begin
                            if (cin || (a > DAA_LIMIT))
                            begin
                                r8 = r8 + DAA_HI;
                                dc = 1'b1;
                            end
                            if (flags_reg.h || (a[3:0] > NIB_NINE))
                            begin
                                r8 = r8 + DAA_LO;
                            end
                        end
                        else
                        begin
                            if (cin)
                            begin
                                r8 = r8 - DAA_HI;
                            end
                            if (flags_reg.h)
                            begin
                                r8 = r8 - DAA_LO;
                            end
                        end
                        flags_next = '{z: (r8 == '0), n: flags_reg.n, h: 1'b0, c: dc};
                    end
                    OP_CPL:
                    begin
                        r8 = ~a;
                        flags_next = '{z: flags_reg.z, n: 1'b1, h: 1'b1, c: cin};
                    end
                    OP_SCF:
                    begin
                        r8 = a;
                        flags_next = '{z: flags_reg.z, n: 1'b0, h: 1'b0, c: 1'b1};
                    end
                    default:
                    begin
                        r8 = a;
                        flags_next = '{z: flags_reg.z, n: 1'b0, h: 1'b0, c: !cin};
                    end
                endcase
                res_next = {8'd0, r8};
            end
            CLS_CB:
            begin
                dc = 1'b0;
                case (q_item.op)
                    OP_RLC:  begin r8 = {a[6:0], a[7]}; dc = a[7]; end
                    OP_RRC:  begin r8 = {a[0], a[7:1]}; dc = a[0]; end
                    OP_RL:   begin r8 = {a[6:0], cin};  dc = a[7]; end
                    OP_RR:   begin r8 = {cin, a[7:1]};  dc = a[0]; end
                    OP_SLA:  begin r8 = {a[6:0], 1'b0}; dc = a[7]; end
                    OP_SRA:  begin r8 = {a[7], a[7:1]}; dc = a[0]; end
                    OP_SWAP: begin r8 = {a[3:0], a[7:4]}; end
                    OP_SRL:  begin r8 = {1'b0, a[7:1]}; dc = a[0]; end
                    OP_BIT:  begin r8 = a; end
                    OP_RES:  begin r8 = a & ~(8'd1 << q_item.bit_idx); end
                    default: begin r8 = a | (8'd1 << q_item.bit_idx); end
                endcase
                res_next = {8'd0, r8};
                if (q_item.op == OP_BIT)
                begin
                    flags_next = '{z: !a[q_item.bit_idx], n: 1'b0, h: 1'b1, c: cin};
                end
                else if ((q_item.op != OP_RES) && (q_item.op != OP_SET))
                begin
                    flags_next = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: dc};
                end
            end
            default:
            begin
                res_next   = '0;
                flags_next = flags_reg;
            end
        endcase
    end

    // pop whenever the output register is free or being drained
    assign q_pop = !q_status.empty && (!m_valid_reg || m_axis_tready);

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (q_pop)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            if (q_pop)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg  <= res_next;
            fout_reg <= flags_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'd0, fout_reg.c, fout_reg.h, fout_reg.n, fout_reg.z, res_reg};

endmodule
